[src/skt_pkg.sv]
// Shared types and codes for the sorted key table.
package skt_pkg;

    localparam int KEY_W   = 16;
    localparam int PAY_W   = 32;
    localparam int POS_W   = 9;
    localparam int CNT_W   = 10;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_EXACT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_GE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_POS   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REPLACED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key_in;
        logic [PAY_W-1:0] payload_in;
        logic [POS_W-1:0] position_in;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position_out;
        logic [KEY_W-1:0]  key_out;
        logic [PAY_W-1:0]  payload_out;
        logic [CNT_W-1:0]  entry_count_out;
    } rsp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

[src/skt_mem.sv]
// Entry memory with one write port and one registered read port.
module skt_mem
    import skt_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  mem_ctl_t      ctl,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/sorted_key_table.sv]
// Top level of the sorted key table: command sequencer, search compare and result register.
//
//   Channel  Signals                    Width  Content
//   request  req_valid, req_ready, req  60     command, key, payload, position
//   response rsp_valid, rsp_ready, rsp  69     status, position, key, payload, count
//
// Find, insert and delete run a binary search through the single read port of the memory,
// with a read state and a compare state per probe. Insert then moves entries up one by one,
// delete moves them down. Read position reads the memory in range; a miss, clear and unused
// codes go straight to the result. The block is ready again as the response appears; a
// stalled response holds the next result back. Reset clears the state, the entry count and
// the response valid flag; the memory needs no clearing.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 512
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_SRCH_W = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_INS_RD = 4'd5;
    localparam logic [3:0] S_INS_WR = 4'd6;
    localparam logic [3:0] S_DEL_RD = 4'd7;
    localparam logic [3:0] S_DEL_WR = 4'd8;
    localparam logic [3:0] S_READ   = 4'd9;
    localparam logic [3:0] S_RESULT = 4'd10;

    logic [3:0]    state_reg, state_next;
    req_t          req_reg, req_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    rsp_t          res_reg, res_next;
    rsp_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          in_range;
    logic          hit;

    skt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CW:1];
    assign in_range = lo_reg < count_reg;
    assign hit      = in_range && (rd_data.key == req_reg.key_in);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_ctl        = '0;
        wr_addr        = AW'(lo_reg);
        wr_data        = '{key: req_reg.key_in, payload: req_reg.payload_in};
        rd_addr        = AW'(lo_reg);

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req;
                    res_next        = '0;
                    res_next.status = STAT_NOT_FOUND;
                    state_next      = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (req_reg.command) inside
                    CMD_INSERT, CMD_DELETE, CMD_FIND_EXACT, CMD_FIND_GE:
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = S_SRCH;
                    end
                    CMD_READ_POS:
                    begin
                        if (CMPW'(req_reg.position_in) < CMPW'(count_reg))
                        begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = AW'(req_reg.position_in);
                            state_next    = S_READ;
                        end
                        else
                        begin
                            state_next = S_RESULT;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next      = '0;
                        res_next.status = STAT_DONE;
                        state_next      = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = AW'(mid);
                    state_next    = S_SRCH_W;
                end
                else
                begin
                    mem_ctl.rd_en = in_range;
                    rd_addr       = AW'(lo_reg);
                    state_next    = S_CHK;
                end
            end
            S_SRCH_W:
            begin
                if (rd_data.key >= req_reg.key_in)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + CW'(1);
                end
                state_next = S_SRCH;
            end
            S_CHK:
            begin
                state_next = S_RESULT;
                unique case (req_reg.command)
                    CMD_INSERT:
                    begin
                        if (hit)
                        begin
                            mem_ctl.wr_en    = 1'b1;
                            res_next.status  = STAT_REPLACED;
                            res_next.position_out = POS_W'(lo_reg);
                            res_next.key_out = req_reg.key_in;
                            res_next.payload_out = req_reg.payload_in;
                        end
                        else if (count_reg >= DEPTH_C)
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            res_next.status  = STAT_DONE;
                            res_next.position_out = POS_W'(lo_reg);
                            res_next.key_out = req_reg.key_in;
                            res_next.payload_out = req_reg.payload_in;
                            idx_next         = count_reg;
                            state_next       = S_INS_RD;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (hit)
                        begin
                            res_next.status  = STAT_DONE;
                            res_next.position_out = POS_W'(lo_reg);
                            res_next.key_out = rd_data.key;
                            res_next.payload_out = rd_data.payload;
                            idx_next         = lo_reg;
                            state_next       = S_DEL_RD;
                        end
                    end
                    CMD_FIND_EXACT, CMD_FIND_GE:
                    begin
                        if (hit || (in_range && req_reg.command == CMD_FIND_GE))
                        begin
                            res_next.status  = STAT_DONE;
                            res_next.position_out = POS_W'(lo_reg);
                            res_next.key_out = rd_data.key;
                            res_next.payload_out = rd_data.payload;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (idx_reg > lo_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = AW'(idx_reg - CW'(1));
                    state_next    = S_INS_WR;
                end
                else
                begin
                    mem_ctl.wr_en = 1'b1;
                    count_next    = count_reg + CW'(1);
                    state_next    = S_RESULT;
                end
            end
            S_INS_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = AW'(idx_reg);
                wr_data       = rd_data;
                idx_next      = idx_reg - CW'(1);
                state_next    = S_INS_RD;
            end
            S_DEL_RD:
            begin
                if ({1'b0, idx_reg} + (CW+1)'(1) < {1'b0, count_reg})
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = AW'(idx_reg + CW'(1));
                    state_next    = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end
            end
            S_DEL_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = AW'(idx_reg);
                wr_data       = rd_data;
                idx_next      = idx_reg + CW'(1);
                state_next    = S_DEL_RD;
            end
            S_READ:
            begin
                res_next.status       = STAT_DONE;
                res_next.position_out = req_reg.position_in;
                res_next.key_out      = rd_data.key;
                res_next.payload_out  = rd_data.payload;
                state_next            = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next                 = res_reg;
                    out_next.entry_count_out = CNT_W'(count_reg);
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

[src/skt_chk.sv]
// Port-level assertions for the sorted key table and the bind that attaches them.
module skt_chk
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 512
)
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Response changed while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request accepted while a command is in progress.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (TABLE_DEPTH > 1023) || (rsp.entry_count_out <= DEPTH_C))
        else $error("Entry count exceeds table depth.");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |-> rsp.entry_count_out == DEPTH_C)
        else $error("Full status with a table that is not full.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_NOT_FOUND |->
            rsp.key_out == '0 && rsp.payload_out == '0 && rsp.position_out == '0)
        else $error("Not found response carries entry data.");

endmodule

bind sorted_key_table skt_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_skt_chk (.*);
